// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/bpog_pkg.sv
// ----------------------------------------------------------------------------
// bpog_pkg
// types and constants of the booklet page order generator
// ----------------------------------------------------------------------------
package bpog_pkg;

  localparam int IDX_W               = 17;
  localparam int QUAD_W              = 14;
  localparam int PHASE_W             = 2;
  localparam int PAGE_COUNT_BITS_DEF = 16;
  localparam int CFG_IDX_W           = 1;
  localparam int PAGE_ALIGN_MASK     = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAGES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_QUADS = 1'd1;

  // phase within one group of four entries
  localparam logic [PHASE_W-1:0] PH_BACK_OUT = 2'd0;
  localparam logic [PHASE_W-1:0] PH_FRONT_A  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_FRONT_B  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_BACK_IN  = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]   group_base;
    logic [IDX_W-1:0]   front_ptr;
    logic [IDX_W-1:0]   back_ptr;
    logic [PHASE_W-1:0] phase;
    logic               finished;
  } seq_state_t;

  typedef struct packed {
    logic [IDX_W-1:0] page_index;
    logic             is_blank;
    logic             is_last;
  } result_t;

endpackage

// File: rtl/bpog_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpog_cfg_regs
// configuration registers: page count and signature size in quads
// ----------------------------------------------------------------------------
module bpog_cfg_regs #(
  parameter int PAGE_COUNT_BITS = bpog_pkg::PAGE_COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bpog_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [((PAGE_COUNT_BITS > bpog_pkg::QUAD_W) ?
                 PAGE_COUNT_BITS : bpog_pkg::QUAD_W)-1:0] cfg_wdata,
  output logic [PAGE_COUNT_BITS-1:0]            num_pages_r,
  output logic [bpog_pkg::QUAD_W-1:0]           sig_quads_r
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pages_r <= '0;
      sig_quads_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpog_pkg::CFG_NUM_PAGES: num_pages_r <= cfg_wdata[PAGE_COUNT_BITS-1:0];
        bpog_pkg::CFG_SIG_QUADS: sig_quads_r <= cfg_wdata[bpog_pkg::QUAD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/bpog_step.sv
// ----------------------------------------------------------------------------
// bpog_step
// one sequence step: next page index, flags and next pointer state
// ----------------------------------------------------------------------------
module bpog_step #(
  parameter int PAGE_COUNT_BITS = bpog_pkg::PAGE_COUNT_BITS_DEF
) (
  input  bpog_pkg::seq_state_t         state,
  input  logic                         restart,
  input  logic [PAGE_COUNT_BITS-1:0]   num_pages,
  input  logic [bpog_pkg::QUAD_W-1:0]  sig_quads,
  output logic                         emit,
  output bpog_pkg::result_t            res,
  output bpog_pkg::seq_state_t         state_nxt
);

  localparam int IW = bpog_pkg::IDX_W;
  localparam int CW = ((IW > PAGE_COUNT_BITS + 1) ? IW : PAGE_COUNT_BITS + 1) + 1;

  logic [CW-1:0] np_ext;
  logic [CW-1:0] sig_size;
  logic [CW-1:0] grp_next;
  logic [IW-1:0] sig_lo;
  logic [IW-1:0] idx;
  logic [IW-1:0] front_step;
  logic [IW-1:0] back_step;
  logic          last;

  always_comb begin
    np_ext = CW'(num_pages);
    if (sig_quads == '0) begin
      sig_size = (np_ext + CW'(bpog_pkg::PAGE_ALIGN_MASK)) & ~CW'(bpog_pkg::PAGE_ALIGN_MASK);
    end else begin
      sig_size = CW'({sig_quads, 2'b00});
    end
    sig_lo     = sig_size[IW-1:0];
    grp_next   = CW'(state.group_base) + sig_size;
    front_step = state.front_ptr + IW'(1);
    back_step  = state.back_ptr - IW'(1);

    state_nxt = state;
    emit      = 1'b0;
    idx       = '0;
    last      = 1'b0;

    if (restart) begin
      state_nxt.group_base = '0;
      state_nxt.front_ptr  = '0;
      state_nxt.finished   = (np_ext == '0) || (sig_size == '0);
      idx                  = sig_lo - IW'(1);
      if (state_nxt.finished) begin
        state_nxt.back_ptr = sig_lo - IW'(1);
        state_nxt.phase    = bpog_pkg::PH_BACK_OUT;
      end else begin
        emit               = 1'b1;
        state_nxt.back_ptr = sig_lo - IW'(2);
        state_nxt.phase    = bpog_pkg::PH_FRONT_A;
      end
    end else if (!state.finished) begin
      emit = 1'b1;
      unique case (state.phase)
        bpog_pkg::PH_BACK_OUT, bpog_pkg::PH_BACK_IN: begin
          idx                = state.back_ptr;
          state_nxt.back_ptr = back_step;
        end
        bpog_pkg::PH_FRONT_A, bpog_pkg::PH_FRONT_B: begin
          idx                 = state.front_ptr;
          state_nxt.front_ptr = front_step;
        end
        default: ;
      endcase

      if (state.phase == bpog_pkg::PH_BACK_IN) begin
        state_nxt.phase = bpog_pkg::PH_BACK_OUT;
        // pointers met: move on to the next signature group or stop
        if (state.front_ptr >= back_step) begin
          if ((sig_size == '0) || (grp_next >= np_ext)) begin
            state_nxt.finished = 1'b1;
            last               = 1'b1;
          end else begin
            state_nxt.group_base = grp_next[IW-1:0];
            state_nxt.front_ptr  = grp_next[IW-1:0];
            state_nxt.back_ptr   = grp_next[IW-1:0] + sig_lo - IW'(1);
          end
        end
      end else begin
        state_nxt.phase = state.phase + bpog_pkg::PHASE_W'(1);
      end
    end

    res.page_index = idx;
    res.is_blank   = (CW'(idx) >= np_ext);
    res.is_last    = last;
  end

endmodule

// File: rtl/booklet_page_order_generator.sv
// ----------------------------------------------------------------------------
// booklet_page_order_generator
// emits the booklet imposition page order, at most one page index per request
// ----------------------------------------------------------------------------
// usage
//   write num_pages (index 0) and signature_quads (index 1, 0 = automatic)
//   on the cfg channel while the block is idle; cfg_ready is always high
//   each transfer on the in channel asks for one entry: restart = 1 begins
//   the sequence anew, restart = 0 asks for the next entry
//   a request gives one result on the out channel, or none when the
//   sequence is finished or empty
//   a request is held in the request register, then its result in the result
//   register; one request per cycle is taken while out_stall is low, and
//   the state update lies combinationally between the two registers
//   reset leaves the configuration registers at zero and the sequence finished, so
//   requests without restart give no result
//   when out_stall is high the result holds and the request register fills,
//   then in_stall rises; nothing is lost or repeated
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module booklet_page_order_generator #(
  parameter int PAGE_COUNT_BITS = bpog_pkg::PAGE_COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bpog_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [((PAGE_COUNT_BITS > bpog_pkg::QUAD_W) ?
                 PAGE_COUNT_BITS : bpog_pkg::QUAD_W)-1:0] cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [bpog_pkg::IDX_W-1:0]            out_page_index,
  output logic                                  out_is_blank,
  output logic                                  out_is_last
);

  logic [PAGE_COUNT_BITS-1:0]     num_pages_r;
  logic [bpog_pkg::QUAD_W-1:0]    sig_quads_r;

  logic                           req_v_r;
  logic                           req_restart_r;
  logic                           out_free;
  logic                           fire;

  bpog_pkg::seq_state_t           state_r;
  bpog_pkg::seq_state_t           state_nxt;
  logic                           step_emit;
  bpog_pkg::result_t              step_res;
  bpog_pkg::result_t              res_r;
  logic                           out_v_r;

  bpog_cfg_regs #(
    .PAGE_COUNT_BITS (PAGE_COUNT_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .num_pages_r (num_pages_r),
    .sig_quads_r (sig_quads_r)
  );

  bpog_step #(
    .PAGE_COUNT_BITS (PAGE_COUNT_BITS)
  ) u_step (
    .state     (state_r),
    .restart   (req_restart_r),
    .num_pages (num_pages_r),
    .sig_quads (sig_quads_r),
    .emit      (step_emit),
    .res       (step_res),
    .state_nxt (state_nxt)
  );

  assign out_free = !out_v_r || !out_stall;
  assign fire     = req_v_r && out_free;
  assign in_stall = req_v_r && !out_free;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (!in_stall) begin
      req_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_restart_r <= in_restart;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{group_base: '0, front_ptr: '0, back_ptr: '0,
                   phase: bpog_pkg::PH_BACK_OUT, finished: 1'b1};
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= step_emit;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step_emit) begin
      res_r <= step_res;
    end
  end

  assign out_valid      = out_v_r;
  assign out_page_index = res_r.page_index;
  assign out_is_blank   = res_r.is_blank;
  assign out_is_last    = res_r.is_last;

  `ASSERT_IMP(a_finished_phase, clk, rst_n, state_r.finished,
              state_r.phase == bpog_pkg::PH_BACK_OUT)
  `ASSERT_NXT(a_last_finishes, clk, rst_n, fire && step_emit && step_res.is_last,
              state_r.finished)
  `ASSERT_NXT(a_no_result_after_end, clk, rst_n,
              fire && state_r.finished && !req_restart_r, !out_valid)
  `ASSERT_IMP(a_stall_needs_req, clk, rst_n, in_stall, req_v_r && out_v_r)

endmodule
